### hdl/jts_pkg.sv
// Shared constants, register map and types for the jet top-k trigger selector.
// No dependencies; every other file in hdl/ imports this package.
`timescale 1ns / 1ps

package jts_pkg;

   // Widths of the kept values. Wider input values saturate into these.
   localparam int PT_BITS   = 16;
   localparam int BTAG_BITS = 11;

   // Fixed field widths of one jet word.
   localparam int JET_PT_W   = 16;
   localparam int JET_ETA_W  = 12;
   localparam int JET_BTAG_W = 12;

   // Kept values per collection, and the number of collections.
   localparam int NPT   = 4;
   localparam int NBT   = 3;
   localparam int NCOLL = 2;

   // Working widths for saturation and for the threshold sums.
   localparam int PT_EXT_W = (PT_BITS > JET_PT_W) ? PT_BITS : JET_PT_W;
   localparam int BT_EXT_W = (BTAG_BITS > JET_BTAG_W) ? BTAG_BITS : JET_BTAG_W;
   localparam int PT_SUM_W = (PT_BITS + 1 > 17) ? PT_BITS + 1 : 17;
   localparam int BT_SUM_W = (BTAG_BITS + 1 > 13) ? BTAG_BITS + 1 : 13;

   localparam logic [PT_EXT_W-1:0] PT_SAT_MAX = PT_EXT_W'((1 << PT_BITS) - 1);
   localparam logic signed [BT_EXT_W-1:0] BT_SAT_MAX =
      BT_EXT_W'((1 << (BTAG_BITS - 1)) - 1);
   localparam logic signed [BT_EXT_W-1:0] BT_SAT_MIN =
      BT_EXT_W'(-(1 << (BTAG_BITS - 1)));

   // Register widths.
   localparam int PAIR_MIN_W  = 17;
   localparam int QUAD_MIN_W  = 17;
   localparam int BTAG_MIN_W  = 13;
   localparam int ETA_LIMIT_W = 11;
   localparam int BT_PT_MIN_W = 16;

   // Configuration port.
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int REG_IDX_W  = 3;

   localparam logic [REG_IDX_W-1:0] REG_PAIR_MIN  = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_QUAD_MIN  = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_BTAG_MIN  = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_ETA_LIMIT = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_BT_PT_MIN = 3'd4;

   localparam logic [PAIR_MIN_W-1:0]  RST_PAIR_MIN  = 17'd1440;
   localparam logic [QUAD_MIN_W-1:0]  RST_QUAD_MIN  = 17'd720;
   localparam logic [BTAG_MIN_W-1:0]  RST_BTAG_MIN  = 13'd717;
   localparam logic [ETA_LIMIT_W-1:0] RST_ETA_LIMIT = 11'd640;
   localparam logic [BT_PT_MIN_W-1:0] RST_BT_PT_MIN = 16'd240;

   // Queue between the classifying front and the top-k back.
   localparam int Q_DEPTH = 4;
   localparam int Q_PTR_W = 2;
   localparam int Q_CNT_W = 3;

   // Current thresholds as seen by the datapath.
   typedef struct packed {
      logic [PAIR_MIN_W-1:0]  pair_min;
      logic [QUAD_MIN_W-1:0]  quad_min;
      logic [BTAG_MIN_W-1:0]  btag_min;
      logic [ETA_LIMIT_W-1:0] eta_limit;
      logic [BT_PT_MIN_W-1:0] bt_pt_min;
   } jts_cfg_type;

   // One classified jet word.
   typedef struct packed {
      logic                 collection;
      logic                 last;
      logic                 pt_keep;
      logic                 bt_keep;
      logic [PT_BITS-1:0]   pt;
      logic [BTAG_BITS-1:0] bt;
   } jts_entry_type;

   // Flags of one event decision.
   typedef struct packed {
      logic accept;
      logic calo_pair_pass;
      logic calo_quad_pass;
      logic calo_btag_pass;
      logic pf_pair_pass;
      logic pf_quad_pass;
      logic pf_btag_pass;
      logic too_few_jets;
   } jts_result_type;

endpackage

### hdl/jts_if.sv
// Valid/ready channel interfaces for jet words in and event decisions out.
// Depends on jts_pkg for the field widths.
`timescale 1ns / 1ps

interface jts_req_if import jts_pkg::*; ();
   logic                         valid;
   logic                         ready;
   logic [JET_PT_W-1:0]          jet_pt;
   logic signed [JET_ETA_W-1:0]  jet_eta;
   logic signed [JET_BTAG_W-1:0] jet_btag;
   logic                         collection;
   logic                         last_of_event;

   modport source (
      output valid, jet_pt, jet_eta, jet_btag, collection, last_of_event,
      input  ready
   );
   modport sink (
      input  valid, jet_pt, jet_eta, jet_btag, collection, last_of_event,
      output ready
   );
endinterface

interface jts_rsp_if import jts_pkg::*; ();
   logic valid;
   logic ready;
   logic accept;
   logic calo_pair_pass;
   logic calo_quad_pass;
   logic calo_btag_pass;
   logic pf_pair_pass;
   logic pf_quad_pass;
   logic pf_btag_pass;
   logic too_few_jets;

   modport source (
      output valid, accept, calo_pair_pass, calo_quad_pass, calo_btag_pass,
             pf_pair_pass, pf_quad_pass, pf_btag_pass, too_few_jets,
      input  ready
   );
   modport sink (
      input  valid, accept, calo_pair_pass, calo_quad_pass, calo_btag_pass,
             pf_pair_pass, pf_quad_pass, pf_btag_pass, too_few_jets,
      output ready
   );
endinterface

### hdl/jts_csr.sv
// APB-style register block holding the selector thresholds.
// Depends on jts_pkg for the register map and reset values.
`timescale 1ns / 1ps

module jts_csr import jts_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output jts_cfg_type           cfg
);

   jts_cfg_type            cfg_ff;
   jts_cfg_type            cfg_in;
   logic [REG_IDX_W-1:0]   reg_idx;
   logic                   wr_en;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[CSR_ADDR_W-1:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign cfg        = cfg_ff;

   // Register write decode; indexes past the map are ignored.
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_PAIR_MIN:  cfg_in.pair_min  = csr_pwdata[PAIR_MIN_W-1:0];
            REG_QUAD_MIN:  cfg_in.quad_min  = csr_pwdata[QUAD_MIN_W-1:0];
            REG_BTAG_MIN:  cfg_in.btag_min  = csr_pwdata[BTAG_MIN_W-1:0];
            REG_ETA_LIMIT: cfg_in.eta_limit = csr_pwdata[ETA_LIMIT_W-1:0];
            REG_BT_PT_MIN: cfg_in.bt_pt_min = csr_pwdata[BT_PT_MIN_W-1:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pair_min  <= RST_PAIR_MIN;
         cfg_ff.quad_min  <= RST_QUAD_MIN;
         cfg_ff.btag_min  <= RST_BTAG_MIN;
         cfg_ff.eta_limit <= RST_ETA_LIMIT;
         cfg_ff.bt_pt_min <= RST_BT_PT_MIN;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read mux; the signed btag threshold reads back sign-extended.
   always_comb begin
      case (reg_idx)
         REG_PAIR_MIN:  csr_prdata = CSR_DATA_W'(cfg_ff.pair_min);
         REG_QUAD_MIN:  csr_prdata = CSR_DATA_W'(cfg_ff.quad_min);
         REG_BTAG_MIN:  csr_prdata = CSR_DATA_W'($signed(cfg_ff.btag_min));
         REG_ETA_LIMIT: csr_prdata = CSR_DATA_W'(cfg_ff.eta_limit);
         REG_BT_PT_MIN: csr_prdata = CSR_DATA_W'(cfg_ff.bt_pt_min);
         default:       csr_prdata = '0;
      endcase
   end

endmodule

### hdl/jts_front.sv
// Front end: takes jet words, saturates pt and btag and classifies each jet
// against the eta limit and the btag pt minimum. Depends on jts_pkg, jts_if.
`timescale 1ns / 1ps

module jts_front import jts_pkg::*; (
   jts_req_if.sink       req_chan,
   input  jts_cfg_type   cfg,
   input  logic          q_ready,
   output logic          q_push,
   output jts_entry_type q_entry
);

   logic [JET_ETA_W-1:0]       abs_eta;
   logic                       eta_ok;
   logic [PT_EXT_W-1:0]        pt_ext;
   logic signed [BT_EXT_W-1:0] bt_ext;
   logic [PT_BITS-1:0]         pt_sat;
   logic [BTAG_BITS-1:0]       bt_sat;

   // Accept a word whenever the queue has room.
   assign req_chan.ready = q_ready;
   assign q_push         = req_chan.valid && q_ready;

   // Absolute eta; the most negative code maps to its magnitude.
   assign abs_eta = req_chan.jet_eta[JET_ETA_W-1] ? (~req_chan.jet_eta + 1'b1)
                                                  : req_chan.jet_eta;
   assign eta_ok  = abs_eta <= JET_ETA_W'(cfg.eta_limit);

   // Saturate pt and btag into the kept widths.
   assign pt_ext = PT_EXT_W'(req_chan.jet_pt);
   assign bt_ext = BT_EXT_W'(req_chan.jet_btag);

   always_comb begin
      if (pt_ext > PT_SAT_MAX) begin
         pt_sat = PT_SAT_MAX[PT_BITS-1:0];
      end else begin
         pt_sat = pt_ext[PT_BITS-1:0];
      end
      if (bt_ext > BT_SAT_MAX) begin
         bt_sat = BT_SAT_MAX[BTAG_BITS-1:0];
      end else if (bt_ext < BT_SAT_MIN) begin
         bt_sat = BT_SAT_MIN[BTAG_BITS-1:0];
      end else begin
         bt_sat = bt_ext[BTAG_BITS-1:0];
      end
   end

   // The btag pt cut uses the raw pt.
   assign q_entry.collection = req_chan.collection;
   assign q_entry.last       = req_chan.last_of_event;
   assign q_entry.pt_keep    = eta_ok;
   assign q_entry.bt_keep    = eta_ok && (req_chan.jet_pt >= cfg.bt_pt_min);
   assign q_entry.pt         = pt_sat;
   assign q_entry.bt         = bt_sat;

endmodule

### hdl/jts_queue.sv
// Short FIFO of classified jet words between the front end and the top-k back.
// Depends on jts_pkg for the word type and depth.
`timescale 1ns / 1ps

module jts_queue import jts_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  jts_entry_type push_entry,
   output logic          push_ready,
   input  logic          pop,
   output logic          head_valid,
   output jts_entry_type head_entry
);

   jts_entry_type        mem_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]   wr_ptr_ff;
   logic [Q_PTR_W-1:0]   wr_ptr_in;
   logic [Q_PTR_W-1:0]   rd_ptr_ff;
   logic [Q_PTR_W-1:0]   rd_ptr_in;
   logic [Q_CNT_W-1:0]   count_ff;
   logic [Q_CNT_W-1:0]   count_in;
   logic                 do_pop;

   assign push_ready = count_ff != Q_CNT_W'(Q_DEPTH);
   assign head_valid = count_ff != '0;
   assign head_entry = mem_ff[rd_ptr_ff];
   assign do_pop     = pop && head_valid;

   // Pointer and fill-count update.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage needs no reset; the fill count guards it.
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

### hdl/jts_back.sv
// Back end: per-collection top-four pt and top-three btag lists with a
// parallel insert, then the six threshold tests and the output word.
// Depends on jts_pkg and jts_if.
`timescale 1ns / 1ps

module jts_back import jts_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  jts_cfg_type   cfg,
   input  logic          head_valid,
   input  jts_entry_type head_entry,
   output logic          pop,
   jts_rsp_if.source     rsp_chan
);

   // Working lists, kept in descending order with prefix valid bits.
   logic [PT_BITS-1:0]          pt_ff   [NCOLL][NPT];
   logic [PT_BITS-1:0]          pt_new  [NCOLL][NPT];
   logic [PT_BITS-1:0]          pt_in   [NCOLL][NPT];
   logic [NPT-1:0]              ptv_ff  [NCOLL];
   logic [NPT-1:0]              ptv_mrg [NCOLL];
   logic [NPT-1:0]              ptv_in  [NCOLL];
   logic [NPT-1:0]              pt_ge   [NCOLL];
   logic signed [BTAG_BITS-1:0] bt_ff   [NCOLL][NBT];
   logic signed [BTAG_BITS-1:0] bt_new  [NCOLL][NBT];
   logic signed [BTAG_BITS-1:0] bt_in   [NCOLL][NBT];
   logic [NBT-1:0]              btv_ff  [NCOLL];
   logic [NBT-1:0]              btv_mrg [NCOLL];
   logic [NBT-1:0]              btv_in  [NCOLL];
   logic [NBT-1:0]              bt_ge   [NCOLL];
   logic [NCOLL-1:0]            upd_pt;
   logic [NCOLL-1:0]            upd_bt;

   // End-of-event snapshot.
   logic [PT_BITS-1:0]          snap_pt_ff  [NCOLL][NPT];
   logic [NPT-1:0]              snap_ptv_ff [NCOLL];
   logic signed [BTAG_BITS-1:0] snap_bt_ff  [NCOLL][NBT];
   logic [NBT-1:0]              snap_btv_ff [NCOLL];
   logic                        snap_valid_ff;
   logic                        snap_valid_in;

   // Output word.
   jts_result_type              res_ff;
   jts_result_type              res_in;
   logic                        out_valid_ff;
   logic                        out_valid_in;

   logic                        snap_move;
   logic                        snap_free;
   logic                        pop_last;
   logic signed [BTAG_BITS-1:0] in_bt;
   logic [NCOLL-1:0]            pair_ok;
   logic [NCOLL-1:0]            quad_ok;
   logic [NCOLL-1:0]            btag_ok;
   logic [PT_SUM_W-1:0]         pair_sum [NCOLL];
   logic [PT_SUM_W-1:0]         quad_sum [NCOLL];
   logic signed [BT_SUM_W-1:0]  btag_sum [NCOLL];

   // Flow control: a last word needs the snapshot slot, others pass freely.
   assign snap_move = snap_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign snap_free = !snap_valid_ff || snap_move;
   assign pop       = head_valid && (!head_entry.last || snap_free);
   assign pop_last  = pop && head_entry.last;
   assign in_bt     = $signed(head_entry.bt);

   // Parallel insert: every kept entry at or above the new value stays put,
   // the new value lands just below them, and the rest shift down one.
   always_comb begin
      for (int c = 0; c < NCOLL; c++) begin
         for (int i = 0; i < NPT; i++) begin
            pt_ge[c][i] = ptv_ff[c][i] && (pt_ff[c][i] >= head_entry.pt);
         end
         pt_new[c][0] = pt_ge[c][0] ? pt_ff[c][0] : head_entry.pt;
         for (int i = 1; i < NPT; i++) begin
            if (pt_ge[c][i]) begin
               pt_new[c][i] = pt_ff[c][i];
            end else if (pt_ge[c][i-1]) begin
               pt_new[c][i] = head_entry.pt;
            end else begin
               pt_new[c][i] = pt_ff[c][i-1];
            end
         end
         upd_pt[c] = pop && (head_entry.collection == 1'(c)) && head_entry.pt_keep
                     && !pt_ge[c][NPT-1];

         for (int i = 0; i < NBT; i++) begin
            bt_ge[c][i] = btv_ff[c][i] && (bt_ff[c][i] >= in_bt);
         end
         bt_new[c][0] = bt_ge[c][0] ? bt_ff[c][0] : in_bt;
         for (int i = 1; i < NBT; i++) begin
            if (bt_ge[c][i]) begin
               bt_new[c][i] = bt_ff[c][i];
            end else if (bt_ge[c][i-1]) begin
               bt_new[c][i] = in_bt;
            end else begin
               bt_new[c][i] = bt_ff[c][i-1];
            end
         end
         upd_bt[c] = pop && (head_entry.collection == 1'(c)) && head_entry.bt_keep
                     && !bt_ge[c][NBT-1];

         for (int i = 0; i < NPT; i++) begin
            pt_in[c][i] = upd_pt[c] ? pt_new[c][i] : pt_ff[c][i];
         end
         ptv_mrg[c] = upd_pt[c] ? {ptv_ff[c][NPT-2:0], 1'b1} : ptv_ff[c];
         for (int i = 0; i < NBT; i++) begin
            bt_in[c][i] = upd_bt[c] ? bt_new[c][i] : bt_ff[c][i];
         end
         btv_mrg[c] = upd_bt[c] ? {btv_ff[c][NBT-2:0], 1'b1} : btv_ff[c];

         // The event ends here: the lists empty for the next event.
         ptv_in[c] = pop_last ? '0 : ptv_mrg[c];
         btv_in[c] = pop_last ? '0 : btv_mrg[c];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < NCOLL; c++) begin
            ptv_ff[c] <= '0;
            btv_ff[c] <= '0;
         end
      end else begin
         ptv_ff <= ptv_in;
         btv_ff <= btv_in;
      end
   end

   always_ff @(posedge clock) begin
      pt_ff <= pt_in;
      bt_ff <= bt_in;
   end

   // Snapshot of the finished lists, taken with the last jet folded in.
   assign snap_valid_in = pop_last ? 1'b1 : (snap_move ? 1'b0 : snap_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         snap_valid_ff <= 1'b0;
      end else begin
         snap_valid_ff <= snap_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop_last) begin
         snap_pt_ff  <= pt_in;
         snap_ptv_ff <= ptv_mrg;
         snap_bt_ff  <= bt_in;
         snap_btv_ff <= btv_mrg;
      end
   end

   // Threshold tests; a test without enough kept jets fails.
   always_comb begin
      for (int c = 0; c < NCOLL; c++) begin
         pair_sum[c] = PT_SUM_W'(snap_pt_ff[c][0]) + PT_SUM_W'(snap_pt_ff[c][1]);
         quad_sum[c] = PT_SUM_W'(snap_pt_ff[c][2]) + PT_SUM_W'(snap_pt_ff[c][3]);
         btag_sum[c] = BT_SUM_W'(snap_bt_ff[c][1]) + BT_SUM_W'(snap_bt_ff[c][2]);
         pair_ok[c]  = snap_ptv_ff[c][1] && (pair_sum[c] >= PT_SUM_W'(cfg.pair_min));
         quad_ok[c]  = snap_ptv_ff[c][NPT-1]
                       && (quad_sum[c] >= PT_SUM_W'(cfg.quad_min));
         btag_ok[c]  = snap_btv_ff[c][NBT-1]
                       && (btag_sum[c] >= BT_SUM_W'($signed(cfg.btag_min)));
      end
      res_in.calo_pair_pass = pair_ok[0];
      res_in.calo_quad_pass = quad_ok[0];
      res_in.calo_btag_pass = btag_ok[0];
      res_in.pf_pair_pass   = pair_ok[1];
      res_in.pf_quad_pass   = quad_ok[1];
      res_in.pf_btag_pass   = btag_ok[1];
      res_in.accept         = (&pair_ok) && (&quad_ok) && (&btag_ok);
      res_in.too_few_jets   = !(snap_ptv_ff[0][NPT-1] && snap_ptv_ff[1][NPT-1]
                                && snap_btv_ff[0][NBT-1] && snap_btv_ff[1][NBT-1]);
   end

   // Output register.
   assign out_valid_in = snap_move ? 1'b1 : (rsp_chan.ready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (snap_move) begin
         res_ff <= res_in;
      end
   end

   assign rsp_chan.valid          = out_valid_ff;
   assign rsp_chan.accept         = res_ff.accept;
   assign rsp_chan.calo_pair_pass = res_ff.calo_pair_pass;
   assign rsp_chan.calo_quad_pass = res_ff.calo_quad_pass;
   assign rsp_chan.calo_btag_pass = res_ff.calo_btag_pass;
   assign rsp_chan.pf_pair_pass   = res_ff.pf_pair_pass;
   assign rsp_chan.pf_quad_pass   = res_ff.pf_quad_pass;
   assign rsp_chan.pf_btag_pass   = res_ff.pf_btag_pass;
   assign rsp_chan.too_few_jets   = res_ff.too_few_jets;

endmodule

### hdl/jet_topk_trigger_select_core.sv
// Jet top-k trigger selector, top level.
// The last jet of an event leaves the queue, is folded into the snapshot of
// the kept lists, and the tests on it are registered as the decision word.
// Throughput: one jet per cycle while the back end keeps taking queued jets.
// Reset (synchronous, active high) empties the queue, the kept lists and the
// output, and loads the default thresholds. Uses jts_pkg and jts_if.
`timescale 1ns / 1ps

module jet_topk_trigger_select_core import jts_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   jts_req_if.sink               req_chan,
   jts_rsp_if.source             rsp_chan,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   jts_cfg_type   cfg;
   logic          q_ready;
   logic          q_push;
   jts_entry_type q_entry;
   logic          head_valid;
   jts_entry_type head_entry;
   logic          pop;

   // Threshold registers.
   jts_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Classification of incoming jet words.
   jts_front u_front (
      .req_chan (req_chan),
      .cfg      (cfg),
      .q_ready  (q_ready),
      .q_push   (q_push),
      .q_entry  (q_entry)
   );

   // Decoupling queue.
   jts_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .push_ready (q_ready),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   // Top-k lists, tests and the decision word.
   jts_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop),
      .rsp_chan   (rsp_chan)
   );

endmodule
